/* rtl/core/rrts_pkg.sv */
// shared types and constants of the round-robin task scheduler
package rrts_pkg;

   localparam int DEF_NUM_TASKS = 16;

   localparam int MODE_W  = 3;
   localparam int TID_W   = 4;
   localparam int STATE_W = 2;
   localparam int TAG_W   = 8;
   localparam int FRAME_W = 64;

   localparam int REQ_FIELDS_W = TID_W + 1 + STATE_W + TAG_W + FRAME_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = TID_W + 3 + TAG_W + FRAME_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESET,
      MODE_INIT,
      MODE_SET_TASK,
      MODE_ENQUEUE,
      MODE_START,
      MODE_YIELD,
      MODE_RESCHED,
      MODE_TRAP
   } mode_type;

   localparam logic [STATE_W-1:0] ST_READY   = 2'd0;
   localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATE_W-1:0] ST_BLOCKED = 2'd2;
   localparam logic [STATE_W-1:0] ST_UNUSED  = 2'd3;

   typedef struct packed {
      mode_type             mode;
      logic [TID_W-1:0]     task_id;
      logic                 present;
      logic [STATE_W-1:0]   new_state;
      logic [TAG_W-1:0]     space_tag;
      logic [FRAME_W-1:0]   frame_addr;
   } op_type;

   typedef struct packed {
      logic [TID_W-1:0]     current_id;
      logic                 current_valid;
      logic                 switched;
      logic                 vm_switch;
      logic [TAG_W-1:0]     vm_space_out;
      logic [FRAME_W-1:0]   return_frame;
   } res_type;

endpackage

/* rtl/core/rrts_front.sv */
// front end: unpacks request beats, classifies them and holds them in a short queue
module rrts_front #(
   parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_id[3:0], task_present[4], new_state[6:5], space_tag[14:7], frame_addr[78:15]
   input  logic [rrts_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [rrts_pkg::MODE_W-1:0]     req_tuser,
   output logic                            op_valid,
   input  logic                            op_ready,
   output rrts_pkg::op_type                op
);
   import rrts_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QUEUE_DEPTH);

   op_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   op_type              dec;
   logic [TID_W-1:0]    tid;
   logic [STATE_W-1:0]  nst;
   logic                push;
   logic                pop;

   assign tid = req_tdata[3:0];
   assign nst = req_tdata[6:5];

   // ids past the table act as a null task, the spare state code as blocked
   always_comb begin
      dec.mode       = mode_type'(req_tuser);
      dec.task_id    = tid;
      dec.present    = req_tdata[4] && (int'(tid) < NUM_TASKS);
      dec.new_state  = (nst == ST_UNUSED) ? ST_BLOCKED : nst;
      dec.space_tag  = req_tdata[14:7];
      dec.frame_addr = req_tdata[78:15];
   end

   assign req_tready = (cnt_ff != QFULL);
   assign op_valid   = (cnt_ff != '0);
   assign op         = q_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QLAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QLAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

/* rtl/core/rrts_back.sv */
// back end: run queue, per-task table and the scheduling sequencer
module rrts_back #(
   parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  rrts_pkg::op_type  op,
   output logic              res_valid,
   input  logic              res_ready,
   output rrts_pkg::res_type res
);
   import rrts_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W = $clog2(NUM_TASKS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_TASKS);

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] frame;
   } rec_type;

   localparam rec_type REC_RESET = '{state: ST_BLOCKED, tag: '0, frame: '0};

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,
      S_EXEC,
      S_FINISH
   } state_type;

   // memories
   logic [IDX_W-1:0]     fifo_mem [NUM_TASKS];
   rec_type              rec_mem  [NUM_TASKS];

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [NUM_TASKS-1:0] queued_ff, queued_in;
   logic [NUM_TASKS-1:0] rec_vld_ff, rec_vld_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 cur_vld_ff, cur_vld_in;
   logic                 resched_ff, resched_in;
   rec_type              cur_rec_ff, cur_rec_in;
   logic [IDX_W-1:0]     nxt_ff, nxt_in;
   logic                 wr2_en_ff, wr2_en_in;
   logic [IDX_W-1:0]     wr2_idx_ff, wr2_idx_in;
   rec_type              wr2_rec_ff, wr2_rec_in;
   res_type              pend_ff, pend_in;
   res_type              res_ff, res_in;
   logic                 res_vld_ff, res_vld_in;
   logic [IDX_W-1:0]     fifo_rd_ff;
   rec_type              rec_rd_ff;
   logic                 rec_rd_vld_ff;

   logic [IDX_W-1:0]     rec_raddr;
   logic                 rec_we;
   logic [IDX_W-1:0]     rec_waddr;
   rec_type              rec_wdata;
   logic                 fifo_we;
   logic [IDX_W-1:0]     push_idx;
   logic                 got, same, pop, push, take, requeue, cur_wr, vm;
   rec_type              nxt_rec, new_cur_rec, nxt_new;
   logic [IDX_W-1:0]     tid_idx;
   logic [FRAME_W-1:0]   ret;

   assign op_ready  = (state_ff == S_IDLE);
   assign res_valid = res_vld_ff;
   assign res       = res_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      queued_in   = queued_ff;
      cur_in      = cur_ff;
      cur_vld_in  = cur_vld_ff;
      resched_in  = resched_ff;
      cur_rec_in  = cur_rec_ff;
      nxt_in      = nxt_ff;
      wr2_en_in   = wr2_en_ff;
      wr2_idx_in  = wr2_idx_ff;
      wr2_rec_in  = wr2_rec_ff;
      pend_in     = pend_ff;
      res_in      = res_ff;
      res_vld_in  = res_vld_ff && !res_ready;
      rec_raddr   = cur_ff;
      rec_we      = 1'b0;
      rec_waddr   = cur_ff;
      rec_wdata   = cur_rec_ff;
      fifo_we     = 1'b0;
      push_idx    = cur_ff;
      got         = (count_ff != '0);
      same        = (nxt_ff == cur_ff);
      pop         = 1'b0;
      push        = 1'b0;
      take        = 1'b0;
      requeue     = 1'b0;
      cur_wr      = 1'b0;
      vm          = 1'b0;
      ret         = '0;
      tid_idx     = IDX_W'(op_ff.task_id);
      nxt_rec     = rec_rd_vld_ff ? rec_rd_ff : REC_RESET;
      new_cur_rec = cur_rec_ff;
      nxt_new     = nxt_rec;

      case (state_ff)
         S_IDLE: begin
            // enqueue looks at the named task, everything else at the current one
            if (op.mode == MODE_ENQUEUE) begin
               rec_raddr = IDX_W'(op.task_id);
            end
            if (op_valid) begin
               op_in    = op;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cur_rec_in = rec_rd_vld_ff ? rec_rd_ff : REC_RESET;
            nxt_in     = fifo_rd_ff;
            rec_raddr  = fifo_rd_ff;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff.mode)
               MODE_RESET, MODE_INIT: begin
                  head_in    = '0;
                  tail_in    = '0;
                  count_in   = '0;
                  queued_in  = '0;
                  resched_in = 1'b0;
                  cur_vld_in = (op_ff.mode == MODE_INIT) && op_ff.present;
                  cur_in     = cur_vld_in ? tid_idx : '0;
               end
               MODE_SET_TASK: begin
                  if (op_ff.present) begin
                     rec_we          = 1'b1;
                     rec_waddr       = tid_idx;
                     rec_wdata.state = op_ff.new_state;
                     rec_wdata.tag   = op_ff.space_tag;
                     rec_wdata.frame = op_ff.frame_addr;
                  end
               end
               MODE_ENQUEUE: begin
                  if (op_ff.present && cur_rec_ff.state == ST_READY &&
                      !queued_ff[tid_idx] && count_ff < FULL_CNT) begin
                     push     = 1'b1;
                     push_idx = tid_idx;
                  end
               end
               MODE_START: begin
                  pop  = got;
                  take = cur_vld_ff && got;
               end
               MODE_YIELD: begin
                  pop     = got;
                  take    = cur_vld_ff && got;
                  requeue = take;
               end
               MODE_RESCHED: begin
                  resched_in = 1'b1;
               end
               MODE_TRAP: begin
                  ret = op_ff.frame_addr;
                  if (resched_ff && cur_vld_ff && op_ff.frame_addr != '0) begin
                     resched_in = 1'b0;
                     pop        = got;
                     // a popped head without a saved frame is dropped
                     if (got && nxt_rec.frame != '0) begin
                        take              = 1'b1;
                        requeue           = 1'b1;
                        cur_wr            = 1'b1;
                        new_cur_rec.frame = op_ff.frame_addr;
                     end
                  end
               end
               default: begin
               end
            endcase

            // running task goes back to the tail; its queued bit may just have been popped
            if (requeue && cur_rec_ff.state == ST_RUNNING) begin
               cur_wr            = 1'b1;
               new_cur_rec.state = ST_READY;
               push              = !queued_ff[cur_ff] || same;
               push_idx          = cur_ff;
            end

            if (cur_wr) begin
               rec_we    = 1'b1;
               rec_waddr = cur_ff;
               rec_wdata = new_cur_rec;
            end

            if (pop) begin
               head_in           = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
               queued_in[nxt_ff] = 1'b0;
            end
            if (push) begin
               fifo_we             = 1'b1;
               tail_in             = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
               queued_in[push_idx] = 1'b1;
            end
            if (pop && !push) begin
               count_in = count_ff - 1'b1;
            end else if (push && !pop) begin
               count_in = count_ff + 1'b1;
            end

            wr2_en_in = take;
            if (take) begin
               nxt_new       = same ? new_cur_rec : nxt_rec;
               nxt_new.state = ST_RUNNING;
               wr2_idx_in    = nxt_ff;
               wr2_rec_in    = nxt_new;
               vm            = (nxt_rec.tag != '0) && (cur_rec_ff.tag != nxt_rec.tag);
               cur_in        = nxt_ff;
               cur_vld_in    = 1'b1;
               if (op_ff.mode == MODE_TRAP) begin
                  ret = nxt_new.frame;
               end
            end

            pend_in.current_id    = cur_vld_in ? TID_W'(cur_in) : '0;
            pend_in.current_valid = cur_vld_in;
            pend_in.switched      = (cur_vld_in != cur_vld_ff) ||
                                    (cur_vld_in && cur_in != cur_ff);
            pend_in.vm_switch     = vm;
            pend_in.vm_space_out  = vm ? nxt_rec.tag : '0;
            pend_in.return_frame  = ret;
            state_in              = S_FINISH;
         end
         S_FINISH: begin
            if (wr2_en_ff) begin
               rec_we    = 1'b1;
               rec_waddr = wr2_idx_ff;
               rec_wdata = wr2_rec_ff;
            end
            if (!res_vld_ff || res_ready) begin
               res_in     = pend_ff;
               res_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rec_vld_in = rec_vld_ff;
      if (rec_we) begin
         rec_vld_in[rec_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         queued_ff  <= '0;
         rec_vld_ff <= '0;
         cur_ff     <= '0;
         cur_vld_ff <= 1'b0;
         resched_ff <= 1'b0;
         wr2_en_ff  <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         queued_ff  <= queued_in;
         rec_vld_ff <= rec_vld_in;
         cur_ff     <= cur_in;
         cur_vld_ff <= cur_vld_in;
         resched_ff <= resched_in;
         wr2_en_ff  <= wr2_en_in;
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_rec_ff    <= cur_rec_in;
      nxt_ff        <= nxt_in;
      wr2_idx_ff    <= wr2_idx_in;
      wr2_rec_ff    <= wr2_rec_in;
      pend_ff       <= pend_in;
      res_ff        <= res_in;
      rec_rd_vld_ff <= rec_vld_ff[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= push_idx;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

endmodule

/* rtl/core/round_robin_task_scheduler.sv */
// top level of the round-robin task scheduler
//
// the req channel carries one scheduling operation per beat: the mode in
// req_tuser, the task id, its present flag, a new state, an address-space tag
// and a trap frame pointer in req_tdata. every request beat yields exactly one
// rsp beat with the current task after the step, a switch flag, the address
// space to activate and, for a trap, the frame to resume.
// a request is taken into a two-entry queue; the sequencer then takes each
// operation through issue, current-task table read, head-task table read and
// update, and write-back and result. it takes no new operation from the queue
// until it is back in issue with the previous result handed to the rsp side.
// reset empties the run queue, drops the current task and marks every task
// blocked with no tag and no frame.
// while rsp_tready is low the finished result is held and the sequencer parks
// one more finished result; the queue then fills with two further requests
// and req_tready drops.
module round_robin_task_scheduler #(
   parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_id[3:0], task_present[4], new_state[6:5], space_tag[14:7], frame_addr[78:15]
   input  logic [rrts_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [rrts_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // current_id[3:0], current_valid[4], switched[5], vm_switch[6],
   // vm_space_out[14:7], return_frame[78:15]
   output logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rrts_pkg::*;

   op_type  op;
   logic    op_valid;
   logic    op_ready;
   res_type res;

   rrts_front #(
      .NUM_TASKS (NUM_TASKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op)
   );

   rrts_back #(
      .NUM_TASKS (NUM_TASKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   assign rsp_tdata = RSP_DATA_W'({res.return_frame, res.vm_space_out, res.vm_switch,
                                   res.switched, res.current_valid, res.current_id});

endmodule
